>>> rtl/core/ndc_pkg.sv
// ----------------------------------------------------------------------------
// ndc_pkg
// shared types and constants for the nibble delta compressor
// ----------------------------------------------------------------------------
package ndc_pkg;

    localparam int BYTE_W   = 8;
    localparam int NIBBLE_W = 4;

    // deltas in -7..+7 fit one code nibble
    localparam logic [BYTE_W-1:0]   DELTA_POS_MAX = 8'h07;
    localparam logic [BYTE_W-1:0]   DELTA_NEG_MIN = 8'hF9;
    // escape nibble, also used as low-nibble padding at end of stream
    localparam logic [NIBBLE_W-1:0] ESC_NIBBLE    = 4'h8;

    // output queue depth: one entry in flight plus room for a two-byte burst
    localparam int QUEUE_DEPTH = 3;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_CNT_W   = 2;

    typedef struct packed {
        logic [BYTE_W-1:0] code;
        logic              last;
    } code_item_t;

endpackage

>>> rtl/core/nibble_delta_compressor_core.sv
// ----------------------------------------------------------------------------
// nibble_delta_compressor_core
// four-bit delta encoder for a byte stream, stream-bus in and out
// ----------------------------------------------------------------------------
// One byte enters per transaction on the s_ side, s_tlast marking the final
// byte of a stream. The first byte of a stream leaves unchanged. Each later
// byte is coded as a nibble holding its modular delta to the byte before it
// when that delta lies in -7..+7, otherwise as the escape nibble 8 followed by
// the byte's two nibbles. Nibbles are packed high nibble first into code bytes
// on the m_ side; at stream end a pending half byte is padded with 8, and the
// final code byte of the stream carries m_tlast. An input byte yields zero,
// one or two code bytes, all computed in the cycle it is accepted and written
// into a three-entry output queue whose head drives m_. The block takes one
// byte per cycle while the queue holds at most one entry; s_tready drops when
// it holds more, as after a byte that yields two code bytes or while the sink
// stalls. s_tready depends on the queue fill count alone, with no
// combinational path from m_tready.
// ----------------------------------------------------------------------------
module nibble_delta_compressor_core
    import ndc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic              s_tlast,   // end_of_stream
    // result channel
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] code_byte
    output logic              m_tlast    // last_code
);

    // stream state
    logic                started_reg, started_next;
    logic [BYTE_W-1:0]   prev_reg, prev_next;
    logic                half_reg, half_next;
    logic [NIBBLE_W-1:0] pend_reg, pend_next;

    // output queue, entry 0 is the head
    code_item_t          queue_reg [QUEUE_DEPTH];
    code_item_t          queue_next [QUEUE_DEPTH];
    logic [COUNT_W-1:0]  count_reg, count_next;

    // results of the current byte
    code_item_t          res0, res1;
    logic [RES_CNT_W-1:0] res_cnt;

    logic                in_fire, out_fire;
    logic [BYTE_W-1:0]   diff;
    logic                small_delta;
    logic [COUNT_W-1:0]  base;

    // room for two results whatever the sink does this cycle
    assign s_tready = (count_reg <= COUNT_W'(QUEUE_DEPTH - 2));
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = queue_reg[0].code;
    assign m_tlast  = queue_reg[0].last;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    assign diff        = s_tdata - prev_reg;
    assign small_delta = (diff <= DELTA_POS_MAX) || (diff >= DELTA_NEG_MIN);

    // coding of one byte: results and next stream state
    always_comb begin
        res0         = '0;
        res1         = '0;
        res_cnt      = '0;
        started_next = 1'b1;
        prev_next    = s_tdata;
        half_next    = half_reg;
        pend_next    = pend_reg;

        if (!started_reg) begin
            // start byte goes out raw and becomes the reference
            res0.code = s_tdata;
            res_cnt   = RES_CNT_W'(1);
            if (s_tlast) begin
                res0.last = 1'b1;
            end
        end else if (small_delta) begin
            if (half_reg) begin
                // completes the pending byte
                res0.code = {pend_reg, diff[NIBBLE_W-1:0]};
                res_cnt   = RES_CNT_W'(1);
                half_next = 1'b0;
                pend_next = '0;
                if (s_tlast) begin
                    res0.last = 1'b1;
                end
            end else if (s_tlast) begin
                // lone nibble flushed with padding
                res0.code = {diff[NIBBLE_W-1:0], ESC_NIBBLE};
                res0.last = 1'b1;
                res_cnt   = RES_CNT_W'(1);
            end else begin
                half_next = 1'b1;
                pend_next = diff[NIBBLE_W-1:0];
            end
        end else if (half_reg) begin
            // escape closes the pending byte, raw byte follows whole
            res0.code = {pend_reg, ESC_NIBBLE};
            res1.code = s_tdata;
            res1.last = s_tlast;
            res_cnt   = RES_CNT_W'(2);
            half_next = 1'b0;
            pend_next = '0;
        end else begin
            // escape plus high nibble, low nibble stays pending
            res0.code = {ESC_NIBBLE, s_tdata[BYTE_W-1:NIBBLE_W]};
            res_cnt   = RES_CNT_W'(1);
            half_next = 1'b1;
            pend_next = s_tdata[NIBBLE_W-1:0];
            if (s_tlast) begin
                res1.code = {s_tdata[NIBBLE_W-1:0], ESC_NIBBLE};
                res1.last = 1'b1;
                res_cnt   = RES_CNT_W'(2);
            end
        end

        // end of stream returns everything to the idle state
        if (s_tlast) begin
            started_next = 1'b0;
            prev_next    = '0;
            half_next    = 1'b0;
            pend_next    = '0;
        end
    end

    // queue: shift on pop, then append the new results behind the survivors
    always_comb begin
        base = count_reg - COUNT_W'(out_fire);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (out_fire && (i < QUEUE_DEPTH - 1)) begin
                queue_next[i] = queue_reg[i+1];
            end else begin
                queue_next[i] = queue_reg[i];
            end
            if (in_fire && (res_cnt != '0) && (base == COUNT_W'(i))) begin
                queue_next[i] = res0;
            end
            if (in_fire && (res_cnt == RES_CNT_W'(2)) && (base + 1'b1 == COUNT_W'(i))) begin
                queue_next[i] = res1;
            end
        end
        if (in_fire) begin
            count_next = base + COUNT_W'(res_cnt);
        end else begin
            count_next = base;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            prev_reg    <= '0;
            half_reg    <= 1'b0;
            pend_reg    <= '0;
            count_reg   <= '0;
        end else begin
            count_reg <= count_next;
            if (in_fire) begin
                started_reg <= started_next;
                prev_reg    <= prev_next;
                half_reg    <= half_next;
                pend_reg    <= pend_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            queue_reg[i] <= queue_next[i];
        end
    end

endmodule

>>> rtl/core/ndc_checks.sv
// ----------------------------------------------------------------------------
// ndc_checks
// port-level checks for the nibble delta compressor
// ----------------------------------------------------------------------------
module ndc_checks
    import ndc_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              s_tlast,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [BYTE_W-1:0] m_tdata,
    input logic              m_tlast
);

    // queue comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // input only stalls while results are waiting
    a_stall_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // end of stream always produces at least one code byte
    a_end_yields_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("no code byte after end of stream");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed while stalled");

endmodule

bind nibble_delta_compressor_core ndc_checks u_ndc_checks (.*);

>>> verif/tb_nibble_delta_compressor_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nibble_delta_compressor_core
// self-checking bench for the four-bit delta encoder
// ----------------------------------------------------------------------------
// Byte streams go in on the s_ side in bursts with random gaps, while the sink
// stalls following its own changing pattern. Each accepted input transaction
// is run through a behavioral encoder here that computes the code bytes it
// must produce. Every m_ transaction is checked field by field against the
// oldest code byte still owed.
// ----------------------------------------------------------------------------
module tb_nibble_delta_compressor_core;
    import ndc_pkg::*;

    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_HOLD} sink_mode_t;

    localparam int RANDOM_BYTES = 700;
    localparam int SHOWN_ERRORS = 10;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tlast;

    // encoder image
    logic                in_stream;
    logic [BYTE_W-1:0]   prior_byte;
    logic                nib_waiting;
    logic [NIBBLE_W-1:0] held_nibble;

    code_item_t owed_codes[$];
    int         failures  = 0;
    int         burst_left = 0;
    int         bytes_sent = 0;
    sink_mode_t sink_mode  = SINK_OPEN;
    logic [5:0] sink_cycle = '0;

    nibble_delta_compressor_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= SHOWN_ERRORS) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    function automatic void clear_encoder();
        in_stream   = 1'b0;
        prior_byte  = '0;
        nib_waiting = 1'b0;
        held_nibble = '0;
    endfunction

    // returns 1 when the nibble completes a code byte
    function automatic logic add_nibble(input logic [NIBBLE_W-1:0] nib,
                                        output logic [BYTE_W-1:0] full_byte);
        full_byte = {held_nibble, nib};
        if (nib_waiting) begin
            nib_waiting = 1'b0;
            held_nibble = '0;
            return 1'b1;
        end
        held_nibble = nib;
        nib_waiting = 1'b1;
        return 1'b0;
    endfunction

    // works out the code bytes one input byte yields and queues them
    task automatic encode_byte(input logic [BYTE_W-1:0] b, input logic eos);
        code_item_t        produced[$];
        logic [BYTE_W-1:0] delta;
        logic [BYTE_W-1:0] full_byte;
        delta = b - prior_byte;
        if (!in_stream) begin
            produced.push_back({b, 1'b0});
            in_stream = 1'b1;
        end else if (delta <= DELTA_POS_MAX || delta >= DELTA_NEG_MIN) begin
            if (add_nibble(delta[NIBBLE_W-1:0], full_byte))
                produced.push_back({full_byte, 1'b0});
        end else if (nib_waiting) begin
            // escape closes the half byte, raw byte follows whole
            produced.push_back({held_nibble, ESC_NIBBLE, 1'b0});
            nib_waiting = 1'b0;
            held_nibble = '0;
            produced.push_back({b, 1'b0});
        end else begin
            if (add_nibble(ESC_NIBBLE, full_byte))
                produced.push_back({full_byte, 1'b0});
            if (add_nibble(b[7:4], full_byte))
                produced.push_back({full_byte, 1'b0});
            if (add_nibble(b[3:0], full_byte))
                produced.push_back({full_byte, 1'b0});
        end
        prior_byte = b;
        if (eos) begin
            if (nib_waiting)
                produced.push_back({held_nibble, ESC_NIBBLE, 1'b0});
            if (produced.size() > 0)
                produced[produced.size()-1].last = 1'b1;
            clear_encoder();
        end
        foreach (produced[i]) owed_codes.push_back(produced[i]);
    endtask

    // one input transaction, with bursts and gaps on the source side
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
        encode_byte(b, eos);
        bytes_sent++;
    endtask

    // sink: ready pattern is picked anew at random whenever the cycle counter wraps
    always @(posedge aclk) begin
        sink_cycle <= sink_cycle + 1'b1;
        if (sink_cycle == 6'd63) begin
            sink_mode <= sink_mode_t'($urandom_range(0, 3));
        end
        case (sink_mode)
            SINK_OPEN:   m_tready <= 1'b1;
            SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
            SINK_SPARSE: m_tready <= (sink_cycle[1:0] == 2'd0);
            default:     m_tready <= (sink_cycle >= 6'd16) && ($urandom_range(0, 2) != 0);
        endcase
    end

    // result checking against the oldest owed code byte
    always @(posedge aclk) begin
        code_item_t owed;
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_codes.size() == 0) begin
                note_failure($sformatf("unexpected code byte %02h last %0b", m_tdata, m_tlast));
            end else begin
                owed = owed_codes.pop_front();
                if (m_tdata !== owed.code)
                    note_failure($sformatf("code byte: expected %02h, got %02h",
                                           owed.code, m_tdata));
                if (m_tlast !== owed.last)
                    note_failure($sformatf("last flag: expected %0b, got %0b (code %02h)",
                                           owed.last, m_tlast, owed.code));
            end
        end
    end

    // start bytes that also end the stream
    task automatic test_lone_bytes();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h5A, 1'b1);
    endtask

    // deltas at both ends of the nibble range, odd count so the end pads
    task automatic test_small_deltas();
        send_byte(8'h80, 1'b0);
        send_byte(8'h87, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // escapes with and without a pending nibble, wraparound deltas
    task automatic test_escapes();
        send_byte(8'h10, 1'b0);
        send_byte(8'h18, 1'b0);    // +8, escape on empty half
        send_byte(8'h08, 1'b0);    // -16, escape with pending nibble
        send_byte(8'hF8, 1'b0);
        send_byte(8'hF9, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h02, 1'b0);    // wraps past zero, +3
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);    // escape with pending nibble ends stream
    endtask

    // escape on the last byte with nothing pending, pad closes it
    task automatic test_escape_at_end();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    // random streams: mostly smooth signals, some noise and flat runs
    task automatic test_random_streams(input int count);
        int                stop_at;
        int                len;
        int                kind;
        logic [BYTE_W-1:0] b;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) begin
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
            if (len > stop_at - bytes_sent) len = stop_at - bytes_sent;
            kind = $urandom_range(0, 9);
            b    = BYTE_W'($urandom_range(0, 255));
            for (int i = 0; i < len; i++) begin
                if (i > 0) begin
                    if (kind >= 7 && kind <= 8)
                        b = BYTE_W'($urandom_range(0, 255));
                    else if (kind == 9)
                        b = b + BYTE_W'($urandom_range(0, 3) == 0 ?
                                        $urandom_range(0, 2) - 1 : 0);
                    else if ($urandom_range(0, 7) == 0)
                        b = b + BYTE_W'($urandom_range(8, 248));
                    else
                        b = b + BYTE_W'($urandom_range(0, 14) - 7);
                end
                send_byte(b, i == len - 1);
            end
        end
    endtask

    initial begin
        clear_encoder();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_lone_bytes();
        test_small_deltas();
        test_escapes();
        test_escape_at_end();
        test_random_streams(RANDOM_BYTES);

        s_tvalid <= 1'b0;
        while (owed_codes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
